@@ src/clcd_pkg.sv @@
// Shared types, codes and init-sequence table for the character LCD interface.
`default_nettype none

package clcd_pkg;

  // Action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_RESTART = 3'd1;
  localparam logic [2:0] ACT_CMD     = 3'd2;
  localparam logic [2:0] ACT_DATA    = 3'd3;
  localparam logic [2:0] ACT_CURSOR  = 3'd4;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BUSY    = 2'd1;
  localparam logic [1:0] STS_BAD_POS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_POWERUP = 2'd0;
  localparam logic [1:0] CFG_INIT    = 2'd1;
  localparam logic [1:0] CFG_PULSE   = 2'd2;
  localparam logic [1:0] CFG_CLEAR   = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TICK_W    = 16;

  // Reset values of the timing registers
  localparam logic [TICK_W-1:0] POWERUP_RST = 16'd15;
  localparam logic [TICK_W-1:0] INIT_RST    = 16'd4;
  localparam logic [TICK_W-1:0] PULSE_RST   = 16'd4;
  localparam logic [TICK_W-1:0] CLEAR_RST   = 16'd5;

  // Display constants
  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_FOURBIT = 4'h2;
  localparam logic [7:0] CMD_FUNCSET = 8'h28;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] ROW1_BASE   = 8'h80;
  localparam logic [7:0] ROW2_BASE   = 8'hC0;
  localparam logic [5:0] MAX_COLUMN  = 6'd40;
  localparam logic [4:0] INIT_LEN    = 5'd14;

  // Kinds of init-sequence entry
  typedef enum logic [1:0] {
    IT_WAIT_POW,
    IT_WAIT_INIT,
    IT_WAIT_CLEAR,
    IT_NIB
  } init_kind_e;

  typedef struct packed {
    init_kind_e kind;
    logic [3:0] nib;
  } init_entry_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic [1:0] status;
  } out_item_t;

  // Init sequence: power-up wait, wake nibbles, 4-bit switch, three commands, clear wait
  function automatic init_entry_t init_entry(input logic [4:0] step);
    init_entry_t e;
    e = '{kind: IT_NIB, nib: 4'h0};
    case (step)
      5'd0:    e = '{kind: IT_WAIT_POW, nib: 4'h0};
      5'd1:    e.nib = NIB_WAKE;
      5'd2:    e = '{kind: IT_WAIT_INIT, nib: 4'h0};
      5'd3:    e.nib = NIB_WAKE;
      5'd4:    e = '{kind: IT_WAIT_INIT, nib: 4'h0};
      5'd5:    e.nib = NIB_WAKE;
      5'd6:    e.nib = NIB_FOURBIT;
      5'd7:    e.nib = CMD_FUNCSET[7:4];
      5'd8:    e.nib = CMD_FUNCSET[3:0];
      5'd9:    e.nib = CMD_DISPON[7:4];
      5'd10:   e.nib = CMD_DISPON[3:0];
      5'd11:   e.nib = CMD_CLEAR[7:4];
      5'd12:   e.nib = CMD_CLEAR[3:0];
      default: e = '{kind: IT_WAIT_CLEAR, nib: 4'h0};
    endcase
    return e;
  endfunction

  // A timing register holding zero counts as one
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

@@ src/clcd_seq.sv @@
// Init/byte sequencer: timing registers, sequencer state and per-transaction update.
`default_nettype none

module clcd_seq
  import clcd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TICK_W-1:0]    cfg_wdata_i,
  input  wire logic                 step_i,
  input  wire in_item_t             item_i,
  output out_item_t                 result_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INIT,
    PH_BYTE
  } phase_e;

  logic [TICK_W-1:0] powerup_q, init_wait_q, pulse_q, clear_wait_q;
  phase_e            phase_q, phase_d;
  logic [4:0]        step_q, step_d;
  logic [TICK_W-1:0] wait_q, wait_d;
  logic [7:0]        pend_q, pend_d;
  logic              low_q, low_d;
  logic              rs_q, rs_d;
  logic              en_q, en_d;
  logic [3:0]        nib_q, nib_d;
  logic [1:0]        status;

  init_entry_t       entry;
  logic              busy;
  logic              pos_ok;
  logic [7:0]        cursor_byte;
  logic [TICK_W-1:0] wait_dec;

  assign entry    = init_entry(step_q);
  assign busy     = (phase_q != PH_IDLE);
  assign wait_dec = wait_q - TICK_W'(1);
  assign pos_ok   = ((item_i.row == 2'd1) || (item_i.row == 2'd2)) &&
                    (item_i.column != 6'd0) && (item_i.column <= MAX_COLUMN);
  assign cursor_byte = ((item_i.row == 2'd1) ? ROW1_BASE : ROW2_BASE) +
                       {2'b00, item_i.column} - 8'd1;

  // Next-state logic for one transaction
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    wait_d  = wait_q;
    pend_d  = pend_q;
    low_d   = low_q;
    rs_d    = rs_q;
    en_d    = en_q;
    nib_d   = nib_q;
    status  = STS_OK;
    case (item_i.action)
      ACT_TICK: begin
        if (busy) begin
          if (wait_q != '0) begin
            // count down; the current entry ends at zero
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              en_d = 1'b0;
              if (phase_q == PH_INIT) begin
                step_d = step_q + 5'd1;
                if (step_d >= INIT_LEN) phase_d = PH_IDLE;
              end else if (!low_q) begin
                phase_d = PH_IDLE;
              end
            end
          end else if (phase_q == PH_INIT) begin
            // load the current init entry
            if (step_q >= INIT_LEN) begin
              phase_d = PH_IDLE;
            end else begin
              unique case (entry.kind)
                IT_WAIT_POW:   wait_d = at_least_one(powerup_q);
                IT_WAIT_INIT:  wait_d = at_least_one(init_wait_q);
                IT_WAIT_CLEAR: wait_d = at_least_one(clear_wait_q);
                IT_NIB: begin
                  nib_d  = entry.nib;
                  en_d   = 1'b1;
                  wait_d = at_least_one(pulse_q);
                end
                default: wait_d = wait_q;
              endcase
            end
          end else begin
            // low half of a byte
            nib_d  = pend_q[3:0];
            en_d   = 1'b1;
            wait_d = at_least_one(pulse_q);
            low_d  = 1'b0;
          end
        end
      end
      ACT_RESTART, ACT_CMD, ACT_DATA, ACT_CURSOR: begin
        if (busy) begin
          status = STS_BUSY;
        end else if (item_i.action == ACT_RESTART) begin
          phase_d = PH_INIT;
          step_d  = '0;
          wait_d  = '0;
          pend_d  = '0;
          low_d   = 1'b0;
          rs_d    = 1'b0;
          en_d    = 1'b0;
          nib_d   = '0;
        end else if ((item_i.action == ACT_CURSOR) && !pos_ok) begin
          status = STS_BAD_POS;
        end else begin
          // byte transfer starts with the high nibble at once
          pend_d  = (item_i.action == ACT_CURSOR) ? cursor_byte : item_i.byte_value;
          rs_d    = (item_i.action == ACT_DATA);
          nib_d   = pend_d[7:4];
          en_d    = 1'b1;
          wait_d  = at_least_one(pulse_q);
          low_d   = 1'b1;
          phase_d = PH_BYTE;
        end
      end
      default: status = STS_OK;
    endcase
  end

  // Pin levels after this transaction
  always_comb begin
    result_o.rs_pin      = rs_d;
    result_o.en_pin      = en_d;
    result_o.data_nibble = nib_d;
    result_o.busy_res    = (phase_d != PH_IDLE);
    result_o.status      = status;
  end

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powerup_q    <= POWERUP_RST;
      init_wait_q  <= INIT_RST;
      pulse_q      <= PULSE_RST;
      clear_wait_q <= CLEAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POWERUP: powerup_q    <= cfg_wdata_i;
        CFG_INIT:    init_wait_q  <= cfg_wdata_i;
        CFG_PULSE:   pulse_q      <= cfg_wdata_i;
        CFG_CLEAR:   clear_wait_q <= cfg_wdata_i;
        default:     powerup_q    <= powerup_q;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      step_q  <= '0;
      wait_q  <= '0;
      pend_q  <= '0;
      low_q   <= 1'b0;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      nib_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      wait_q  <= wait_d;
      pend_q  <= pend_d;
      low_q   <= low_d;
      rs_q    <= rs_d;
      en_q    <= en_d;
      nib_q   <= nib_d;
    end
  end

endmodule

`default_nettype wire

@@ src/clcd_out_buf.sv @@
// Two-entry result buffer between the sequencer and the output channel.
`default_nettype none

module clcd_out_buf
  import clcd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_item_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  out_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign full_o      = cnt_q[1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot_q[rd_q];

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_item_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ src/char_lcd_4bit_interface_core.sv @@
// Top level of the 4-bit character LCD interface.
`default_nettype none

// Drives a character LCD over a 4-bit bus. Every transaction (a tick, a restart,
// a command or data byte, or a cursor move) yields exactly one result carrying
// the RS, EN and D4..D7 levels after the transaction, a busy flag and a status.
// The block takes one transaction per clock while the output buffer has room:
// each is held in an input register, applied to the sequencer and its result
// written into a two-entry output buffer, from which it is offered on the
// output. Input is stalled only while the output buffer is full. After reset
// the power-up sequence is pending and advances on ticks; the timing registers
// may be written only while no transaction is in flight.
module char_lcd_4bit_interface_core
  import clcd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TICK_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o
);

  in_item_t  item_q;
  logic      item_valid_q;
  logic      buf_full;
  logic      advance;
  out_item_t result;

  assign advance    = item_valid_q && !buf_full;
  assign in_ready_o = !item_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_item_i;
  end

  clcd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (item_q),
    .result_o    (result)
  );

  clcd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_item_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
